@@ hw/rtl/saturation_rate_and_derivative_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for saturation_rate_and_derivative
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SATURATION_RATE_AND_DERIVATIVE_MACROS_SVH
`define SATURATION_RATE_AND_DERIVATIVE_MACROS_SVH
`ifndef SYNTH
`define SRD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRD_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SRD_ASSERT(lbl, prop, msg)
`define SRD_NEVER(lbl, expr, msg)
`endif
`endif

@@ hw/rtl/srd_pkg.sv @@
// ----------------------------------------------------------------------------
// srd_pkg
// Types, codes and helper functions for the saturating rate block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    localparam logic [2:0] REG_RATE  = 3'd0;
    localparam logic [2:0] REG_KM0   = 3'd1;
    localparam logic [2:0] REG_KM1   = 3'd2;
    localparam logic [2:0] REG_KM2   = 3'd3;
    localparam logic [2:0] REG_ORD0  = 3'd4;
    localparam logic [2:0] REG_ORD1  = 3'd5;
    localparam logic [2:0] REG_ORD2  = 3'd6;
    localparam logic [2:0] REG_SUBST = 3'd7;

    localparam logic [63:0] VMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] UMAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        S_IDLE, S_REACT, S_B_CHK, S_B_MUL, S_B_DIV, S_AFTER, S_P_MUL, S_S_DIV,
        S_S_MUL, S_D_START, S_D_K, S_D_J, S_D_JM, S_D_PDONE, S_D_MUL, S_D_DIV,
        S_D_GMUL, S_D_GDIV, S_D_GFIN, S_FINISH
    } state_t;

    typedef struct packed {
        logic        sat;
        logic [63:0] v;
    } fit_t;

    function automatic logic [12:0] fact(input logic [2:0] k);
        logic [12:0] f;
        case (k)
            3'd0, 3'd1: f = 13'd1;
            3'd2:       f = 13'd2;
            3'd3:       f = 13'd6;
            3'd4:       f = 13'd24;
            3'd5:       f = 13'd120;
            3'd6:       f = 13'd720;
            default:    f = 13'd5040;
        endcase
        return f;
    endfunction

    function automatic fit_t fit(input logic [127:0] w);
        fit_t r;
        if (w[127:63] != '0)
        begin
            r.sat = 1'b1;
            r.v   = VMAX;
        end
        else
        begin
            r.sat = 1'b0;
            r.v   = w[63:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/saturation_rate_and_derivative.sv @@
// ----------------------------------------------------------------------------
// saturation_rate_and_derivative
// Saturating reaction propensity and its partial derivative, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the rate
//   constant, saturation constants, orders and substrate count; always ready.
//   s channel takes one item: tdata = populations, tuser = command, chosen.
//   m channel returns one result: tdata = value (Q24), tuser = status.
// Datapath: one item at a time through a serial shift-add multiplier
//   and a restoring divider. A binomial step is one product and one
//   divide; each plain reactant adds a product and each substrate a divide
//   and a product; a derivative adds up to order^2 products, a scaling
//   divide and, for a substrate, a saturation pass. A range error result
//   goes from its input transfer straight to the finish state and then
//   into the output register once that register is free.
// s_tready is high only while the sequencer is idle.
// The result sits in an output register; a stalled receiver holds it there
//   and the next item may be accepted meanwhile, finishing once it drains.
// Reset restores the register defaults and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "saturation_rate_and_derivative_macros.svh"

module saturation_rate_and_derivative #(
    parameter int MAX_REACTANTS = 3,
    parameter int MAX_ORDER     = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [39:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // population_0, population_1, population_2
    input  wire logic [71:0] s_tdata,
    // command, chosen_reactant
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // value
    output logic [63:0]      m_tdata,
    // status
    output logic [1:0]       m_tuser
);
    import srd_pkg::*;

    logic [39:0] rate_reg;
    logic [39:0] km_reg [3];
    logic [2:0]  ord_reg [3];
    logic [1:0]  subst_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            km_reg[0] <= 40'd65536;
            km_reg[1] <= 40'd65536;
            km_reg[2] <= 40'd65536;
            ord_reg[0] <= '0;
            ord_reg[1] <= '0;
            ord_reg[2] <= '0;
            subst_reg <= 2'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_RATE:  rate_reg   <= cfg_data;
                REG_KM0:   km_reg[0]  <= cfg_data;
                REG_KM1:   km_reg[1]  <= cfg_data;
                REG_KM2:   km_reg[2]  <= cfg_data;
                REG_ORD0:  ord_reg[0] <= cfg_data[2:0];
                REG_ORD1:  ord_reg[1] <= cfg_data[2:0];
                REG_ORD2:  ord_reg[2] <= cfg_data[2:0];
                REG_SUBST: subst_reg  <= cfg_data[1:0];
                default:   rate_reg   <= rate_reg;
            endcase
        end
    end

    // ---------------- serial multiplier ----------------
    logic         mul_start;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_x_reg, mul_acc_reg;
    logic [63:0]  mul_y_reg;
    logic [5:0]   mul_cnt_reg;
    logic         mul_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else if (mul_start)
        begin
            mul_busy_reg <= 1'b1;
            mul_cnt_reg  <= '0;
        end
        else if (mul_busy_reg)
        begin
            mul_cnt_reg <= mul_cnt_reg + 6'd1;
            if (mul_cnt_reg == 6'd63)
                mul_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_x_reg   <= {64'h0, mul_a};
            mul_y_reg   <= mul_b;
            mul_acc_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mul_y_reg[0])
                mul_acc_reg <= mul_acc_reg + mul_x_reg;
            mul_x_reg <= {mul_x_reg[126:0], 1'b0};
            mul_y_reg <= {1'b0, mul_y_reg[63:1]};
        end
    end

    // ---------------- restoring divider ----------------
    logic         div_start;
    logic [127:0] div_n, div_d;
    logic [127:0] div_num_reg, div_den_reg, div_rem_reg, div_quo_reg;
    logic [6:0]   div_cnt_reg;
    logic         div_busy_reg;
    logic         div_dz_reg;
    logic [127:0] div_rsh, div_q;
    logic         div_take;

    assign div_rsh  = {div_rem_reg[126:0], div_num_reg[127]};
    assign div_take = div_rem_reg[127] || (div_rsh >= div_den_reg);
    assign div_q    = div_dz_reg ? '0 : div_quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + 7'd1;
            if (div_cnt_reg == 7'd127)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_num_reg <= div_n;
            div_den_reg <= div_d;
            div_rem_reg <= '0;
            div_quo_reg <= '0;
            div_dz_reg  <= (div_d == '0);
        end
        else if (div_busy_reg)
        begin
            div_num_reg <= {div_num_reg[126:0], 1'b0};
            div_rem_reg <= div_take ? (div_rsh - div_den_reg) : div_rsh;
            div_quo_reg <= {div_quo_reg[126:0], div_take};
        end
    end

    // ---------------- sequencer ----------------
    state_t      state_reg, state_next;
    logic [23:0] pop_reg [3];
    logic        cmd_reg, cmd_next;
    logic [1:0]  ch_reg, ch_next;
    logic [1:0]  i_reg, i_next;
    logic [2:0]  j_reg, j_next, k_reg, k_next;
    logic [63:0] r_reg, r_next, t_reg, t_next, p_reg, p_next;
    logic [63:0] prod_reg, prod_next, sum_reg, sum_next;
    logic        capped_reg, capped_next, pcap_reg, pcap_next;
    logic        neg_reg, neg_next, sat_reg, sat_next, zero_reg, zero_next;
    logic        range_reg, range_next;
    logic        load_pop, out_load;

    logic [1:0]  count;
    logic [2:0]  oe [3];
    logic [23:0] x_cur;
    logic [39:0] km_cur;
    logic [2:0]  n_cur;
    logic        sub_cur, chosen_cur;
    logic [80:0] den_cur;
    logic [63:0] x_sub_j;
    logic [2:0]  xs, nm1x;
    logic [64:0] sum_add;
    fit_t        f_tmp;

    always_comb
    begin
        for (int q = 0; q < 3; q++)
            oe[q] = (ord_reg[q] > 3'(MAX_ORDER)) ? 3'(MAX_ORDER) : ord_reg[q];
        count = 2'd0;
        if (MAX_REACTANTS >= 1 && oe[0] != 3'd0)
        begin
            count = 2'd1;
            if (MAX_REACTANTS >= 2 && oe[1] != 3'd0)
            begin
                count = 2'd2;
                if (MAX_REACTANTS >= 3 && oe[2] != 3'd0)
                    count = 2'd3;
            end
        end
        case (i_reg)
            2'd0:
            begin
                x_cur = pop_reg[0]; km_cur = km_reg[0]; n_cur = oe[0];
            end
            2'd1:
            begin
                x_cur = pop_reg[1]; km_cur = km_reg[1]; n_cur = oe[1];
            end
            default:
            begin
                x_cur = pop_reg[2]; km_cur = km_reg[2]; n_cur = oe[2];
            end
        endcase
    end

    assign sub_cur    = i_reg < subst_reg;
    assign chosen_cur = cmd_reg && (i_reg == ch_reg);
    assign den_cur    = {1'b0, t_reg, 16'h0} + 81'(km_cur);
    assign x_sub_j    = 64'(x_cur) - 64'(j_reg);
    assign xs         = x_cur[2:0];
    assign nm1x       = n_cur - 3'd1 - xs;
    assign sum_add    = {1'b0, sum_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_pop)
        begin
            pop_reg[0] <= s_tdata[23:0];
            pop_reg[1] <= s_tdata[47:24];
            pop_reg[2] <= s_tdata[71:48];
        end
        cmd_reg <= cmd_next;   ch_reg <= ch_next;
        i_reg <= i_next;       j_reg <= j_next;      k_reg <= k_next;
        r_reg <= r_next;       t_reg <= t_next;      p_reg <= p_next;
        prod_reg <= prod_next; sum_reg <= sum_next;
        capped_reg <= capped_next; pcap_reg <= pcap_next;
        neg_reg <= neg_next;   sat_reg <= sat_next;  zero_reg <= zero_next;
        range_reg <= range_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;   ch_next = ch_reg;
        i_next = i_reg;       j_next = j_reg;       k_next = k_reg;
        r_next = r_reg;       t_next = t_reg;       p_next = p_reg;
        prod_next = prod_reg; sum_next = sum_reg;
        capped_next = capped_reg; pcap_next = pcap_reg;
        neg_next = neg_reg;   sat_next = sat_reg;   zero_next = zero_reg;
        range_next = range_reg;
        load_pop = 1'b0;      out_load = 1'b0;
        mul_start = 1'b0;     mul_a = '0;           mul_b = '0;
        div_start = 1'b0;     div_n = '0;           div_d = '0;
        f_tmp = '0;
        s_tready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    load_pop   = 1'b1;
                    cmd_next   = s_tuser[0];
                    ch_next    = s_tuser[2:1];
                    r_next     = {16'h0, rate_reg, 8'h0};
                    zero_next  = (rate_reg == '0);
                    sat_next   = 1'b0;
                    neg_next   = 1'b0;
                    i_next     = 2'd0;
                    range_next = s_tuser[0] && (s_tuser[2:1] >= count);
                    state_next = (s_tuser[0] && (s_tuser[2:1] >= count)) ? S_FINISH : S_REACT;
                end
            end
            S_REACT:
            begin
                if (i_reg == count)
                    state_next = S_FINISH;
                else
                begin
                    t_next = 64'd1;
                    capped_next = 1'b0;
                    j_next = 3'd0;
                    state_next = S_B_CHK;
                end
            end
            S_B_CHK:
            begin
                if (j_reg == n_cur)
                    state_next = S_AFTER;
                else if (x_cur <= 24'(j_reg))
                begin
                    t_next = '0;
                    state_next = S_AFTER;
                end
                else
                begin
                    mul_start = 1'b1; mul_a = t_reg; mul_b = x_sub_j;
                    state_next = S_B_MUL;
                end
            end
            S_B_MUL:
            begin
                if (!mul_busy_reg)
                begin
                    div_start = 1'b1;
                    div_n = mul_acc_reg;
                    div_d = 128'(j_reg) + 128'd1;
                    state_next = S_B_DIV;
                end
            end
            S_B_DIV:
            begin
                if (!div_busy_reg)
                begin
                    if (div_q[127:64] != '0)
                    begin
                        t_next = UMAX;
                        capped_next = 1'b1;
                    end
                    else
                        t_next = div_q[63:0];
                    j_next = j_reg + 3'd1;
                    state_next = S_B_CHK;
                end
            end
            S_AFTER:
            begin
                if (chosen_cur)
                    state_next = S_D_START;
                else if (sub_cur)
                begin
                    if (t_reg == '0) zero_next = 1'b1;
                    div_start = 1'b1;
                    div_n = {16'h0, t_reg, 48'h0};
                    div_d = 128'(den_cur);
                    state_next = S_S_DIV;
                end
                else
                begin
                    if (t_reg == '0) zero_next = 1'b1;
                    if (capped_reg) sat_next = 1'b1;
                    mul_start = 1'b1; mul_a = r_reg; mul_b = t_reg;
                    state_next = S_P_MUL;
                end
            end
            S_P_MUL:
            begin
                if (!mul_busy_reg)
                begin
                    f_tmp = fit(mul_acc_reg);
                    r_next = f_tmp.v;
                    sat_next = sat_reg | f_tmp.sat;
                    i_next = i_reg + 2'd1;
                    state_next = S_REACT;
                end
            end
            S_S_DIV:
            begin
                if (!div_busy_reg)
                begin
                    mul_start = 1'b1; mul_a = r_reg; mul_b = div_q[63:0];
                    state_next = S_S_MUL;
                end
            end
            S_S_MUL, S_D_GFIN:
            begin
                if (!mul_busy_reg)
                begin
                    f_tmp = fit({32'h0, mul_acc_reg[127:32]});
                    r_next = f_tmp.v;
                    sat_next = sat_reg | f_tmp.sat;
                    i_next = i_reg + 2'd1;
                    state_next = S_REACT;
                end
            end
            S_D_START:
            begin
                pcap_next = 1'b0;
                if (x_cur < 24'(n_cur))
                begin
                    neg_next = nm1x[0];
                    p_next = 64'(fact(xs) * fact(nm1x));
                    state_next = S_D_PDONE;
                end
                else
                begin
                    sum_next = '0;
                    k_next = 3'd0;
                    state_next = S_D_K;
                end
            end
            S_D_K:
            begin
                if (k_reg == n_cur)
                begin
                    p_next = sum_reg;
                    state_next = S_D_PDONE;
                end
                else
                begin
                    prod_next = 64'd1;
                    j_next = 3'd0;
                    state_next = S_D_J;
                end
            end
            S_D_J:
            begin
                if (j_reg == n_cur)
                begin
                    if (sum_add[64])
                    begin
                        sum_next = UMAX;
                        pcap_next = 1'b1;
                    end
                    else
                        sum_next = sum_add[63:0];
                    k_next = k_reg + 3'd1;
                    state_next = S_D_K;
                end
                else if (j_reg == k_reg)
                    j_next = j_reg + 3'd1;
                else
                begin
                    mul_start = 1'b1; mul_a = prod_reg; mul_b = x_sub_j;
                    state_next = S_D_JM;
                end
            end
            S_D_JM:
            begin
                if (!mul_busy_reg)
                begin
                    if (mul_acc_reg[127:64] != '0)
                    begin
                        prod_next = UMAX;
                        pcap_next = 1'b1;
                    end
                    else
                        prod_next = mul_acc_reg[63:0];
                    j_next = j_reg + 3'd1;
                    state_next = S_D_J;
                end
            end
            S_D_PDONE:
            begin
                if (p_reg == '0) zero_next = 1'b1;
                if (pcap_reg) sat_next = 1'b1;
                mul_start = 1'b1; mul_a = r_reg; mul_b = p_reg;
                state_next = S_D_MUL;
            end
            S_D_MUL:
            begin
                if (!mul_busy_reg)
                begin
                    div_start = 1'b1;
                    div_n = mul_acc_reg;
                    div_d = 128'(fact(n_cur));
                    state_next = S_D_DIV;
                end
            end
            S_D_DIV:
            begin
                if (!div_busy_reg)
                begin
                    f_tmp = fit(div_q);
                    r_next = f_tmp.v;
                    sat_next = sat_reg | f_tmp.sat;
                    if (sub_cur)
                    begin
                        if (km_cur == '0) zero_next = 1'b1;
                        if (den_cur[80:64] == '0)
                        begin
                            mul_start = 1'b1;
                            mul_a = den_cur[63:0];
                            mul_b = den_cur[63:0];
                            state_next = S_D_GMUL;
                        end
                        else
                        begin
                            r_next = '0;
                            i_next = i_reg + 2'd1;
                            state_next = S_REACT;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + 2'd1;
                        state_next = S_REACT;
                    end
                end
            end
            S_D_GMUL:
            begin
                if (!mul_busy_reg)
                begin
                    div_start = 1'b1;
                    div_n = {40'h0, km_cur, 48'h0};
                    div_d = mul_acc_reg;
                    state_next = S_D_GDIV;
                end
            end
            S_D_GDIV:
            begin
                if (!div_busy_reg)
                begin
                    mul_start = 1'b1; mul_a = r_reg; mul_b = div_q[63:0];
                    state_next = S_D_GFIN;
                end
            end
            S_FINISH:
            begin
                if (!m_tvalid || m_tready)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------- output register ----------------
    logic        out_valid_reg;
    logic [63:0] out_value_reg;
    logic [1:0]  out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (range_reg)
            begin
                out_value_reg  <= '0;
                out_status_reg <= ST_RANGE;
            end
            else if (zero_reg)
            begin
                out_value_reg  <= '0;
                out_status_reg <= ST_OK;
            end
            else
            begin
                out_value_reg  <= neg_reg ? (64'h0 - r_reg) : r_reg;
                out_status_reg <= sat_reg ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    // ---------------- assertions ----------------
    `SRD_NEVER(a_units_exclusive, mul_busy_reg && div_busy_reg, "mul and div both busy")
    `SRD_ASSERT(a_range_zero, (m_tvalid && m_tuser == ST_RANGE) |-> (m_tdata == '0), "range value")
    `SRD_ASSERT(a_accept_busy, (s_tvalid && s_tready) |=> !s_tready, "ready after accept")

endmodule

`default_nettype wire
